@@ hdl/length_framed_packet_deframer_top_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the length-framed packet deframer
// Shared forms for concurrent checks on the top-level ports.
// ---------------------------------------------------------------------------
`ifndef LENGTH_FRAMED_PACKET_DEFRAMER_TOP_ASSERT_SVH
`define LENGTH_FRAMED_PACKET_DEFRAMER_TOP_ASSERT_SVH

// check that is off while reset is asserted
`define LPD_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("lpd check failed");

// check that also runs during reset
`define LPD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("lpd reset check failed");

`endif

@@ hdl/lpd_pkg.sv @@
// ---------------------------------------------------------------------------
// lpd_pkg
// Types and constants shared by the deframer modules.
// ---------------------------------------------------------------------------
`default_nettype none

package lpd_pkg;

    localparam int CHANNEL_TOTAL = 8;
    localparam int HEADER_BYTES  = 6;
    localparam int MASK_BITS     = 8;
    localparam int CH_W          = $clog2(MASK_BITS);
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    // one result between front and back
    typedef struct packed {
        logic [7:0]      data_byte;
        logic [CH_W-1:0] channel;
        logic [15:0]     length;
        logic [7:0]      sequence_num;
        logic            has_payload;
        logic            last;
    } item_t;

endpackage

`default_nettype wire

@@ hdl/lpd_front.sv @@
// ---------------------------------------------------------------------------
// lpd_front
// Header parser: tracks header position, payload count and buffer drop,
// and pushes one item per delivered byte or empty-packet notice.
// ---------------------------------------------------------------------------
`default_nettype none

module lpd_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           data_byte,
    input  wire logic [15:0]          bytes_left,
    input  wire logic                 first_of_buffer,
    input  wire logic                 cfg_we,
    input  wire logic [7:0]           cfg_mask,
    input  wire logic                 q_full,
    output logic                      push,
    output lpd_pkg::item_t            push_item
);

    localparam logic [2:0] HDR_START = 3'd0;
    localparam logic [2:0] HDR_CH_HI = 3'd1;
    localparam logic [2:0] HDR_CH_LO = 3'd2;
    localparam logic [2:0] HDR_LN_HI = 3'd3;
    localparam logic [2:0] HDR_LN_LO = 3'd4;
    localparam logic [2:0] HDR_SEQ   = 3'd5;

    logic [7:0]  mask_reg;
    logic [2:0]  hpos_reg, hpos_next;
    logic [15:0] chan_reg, chan_next;
    logic [15:0] len_reg,  len_next;
    logic [7:0]  seq_reg,  seq_next;
    logic [15:0] rem_reg,  rem_next;
    logic        drop_reg, drop_next;

    logic        accept;
    logic [2:0]  hpos_cur;
    logic [15:0] rem_cur, rem_dec, after;
    logic        drop_cur, chan_on, emit;
    lpd_pkg::item_t item;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign after    = (bytes_left != 16'd0) ? bytes_left - 16'd1 : 16'd0;
    assign rem_dec  = rem_cur - 16'd1;
    assign chan_on  = (chan_next < 16'(lpd_pkg::MASK_BITS))
                      && mask_reg[chan_next[lpd_pkg::CH_W-1:0]];

    always_comb begin
        // a new buffer restarts parsing before the byte is taken
        hpos_cur  = first_of_buffer ? HDR_START : hpos_reg;
        rem_cur   = first_of_buffer ? 16'd0 : rem_reg;
        drop_cur  = first_of_buffer ? 1'b0 : drop_reg;
        hpos_next = hpos_cur;
        rem_next  = rem_cur;
        drop_next = drop_cur;
        chan_next = chan_reg;
        len_next  = len_reg;
        seq_next  = seq_reg;
        emit      = 1'b0;
        item.data_byte    = data_byte;
        item.has_payload  = 1'b1;
        item.last         = 1'b0;
        if (drop_cur) begin
            if (bytes_left <= 16'd1) begin
                drop_next = 1'b0;
            end
        end else if (rem_cur != 16'd0) begin
            rem_next  = rem_dec;
            emit      = chan_on;
            item.last = (rem_dec == 16'd0);
        end else begin
            case (hpos_cur)
                HDR_START: begin
                    if (bytes_left < 16'(lpd_pkg::HEADER_BYTES)) begin
                        drop_next = (bytes_left > 16'd1);
                    end else begin
                        hpos_next = HDR_CH_HI;
                    end
                end
                HDR_CH_HI: begin
                    chan_next = {data_byte, 8'd0};
                    hpos_next = HDR_CH_LO;
                end
                HDR_CH_LO: begin
                    chan_next = {chan_reg[15:8], data_byte};
                    hpos_next = HDR_LN_HI;
                end
                HDR_LN_HI: begin
                    len_next  = {data_byte, 8'd0};
                    hpos_next = HDR_LN_LO;
                end
                HDR_LN_LO: begin
                    len_next  = {len_reg[15:8], data_byte};
                    hpos_next = HDR_SEQ;
                end
                default: begin
                    seq_next  = data_byte;
                    hpos_next = HDR_START;
                    if ((chan_reg >= 16'(lpd_pkg::CHANNEL_TOTAL)) || (len_reg > after)) begin
                        drop_next = (bytes_left > 16'd1);
                    end else if (len_reg != 16'd0) begin
                        rem_next = len_reg;
                    end else begin
                        emit             = chan_on;
                        item.has_payload = 1'b0;
                        item.last        = 1'b1;
                    end
                end
            endcase
        end
        item.channel      = chan_next[lpd_pkg::CH_W-1:0];
        item.length       = len_next;
        item.sequence_num = seq_next;
    end

    assign push      = accept && emit;
    assign push_item = item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= 8'd0;
            hpos_reg <= HDR_START;
            chan_reg <= 16'd0;
            len_reg  <= 16'd0;
            seq_reg  <= 8'd0;
            rem_reg  <= 16'd0;
            drop_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                mask_reg <= cfg_mask;
            end
            if (accept) begin
                hpos_reg <= hpos_next;
                chan_reg <= chan_next;
                len_reg  <= len_next;
                seq_reg  <= seq_next;
                rem_reg  <= rem_next;
                drop_reg <= drop_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/lpd_queue.sv @@
// ---------------------------------------------------------------------------
// lpd_queue
// Short item queue that decouples the parser from the output stage.
// ---------------------------------------------------------------------------
`default_nettype none

module lpd_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire lpd_pkg::item_t  push_item,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output lpd_pkg::item_t       head_item
);

    lpd_pkg::item_t                mem [lpd_pkg::QUEUE_DEPTH];
    logic [lpd_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [lpd_pkg::QPTR_W:0]      count_reg, count_next;

    assign full      = (count_reg == (lpd_pkg::QPTR_W+1)'(lpd_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/lpd_back.sv @@
// ---------------------------------------------------------------------------
// lpd_back
// Output stage: pops queued items into the result register and packs them.
// ---------------------------------------------------------------------------
`default_nettype none

module lpd_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_not_empty,
    input  wire lpd_pkg::item_t  q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [39:0]          out_data,
    output logic                 out_user,
    output logic                 out_last
);

    logic           valid_reg;
    lpd_pkg::item_t item_reg;
    logic           load;

    assign load      = !valid_reg || out_ready;
    assign q_pop     = q_not_empty && load;
    assign out_valid = valid_reg;
    assign out_user  = item_reg.has_payload;
    assign out_last  = item_reg.last;
    // a notice carries a zero data byte
    assign out_data  = {5'd0, item_reg.sequence_num, item_reg.length, item_reg.channel,
                        (item_reg.has_payload ? item_reg.data_byte : 8'd0)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= q_not_empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_item;
        end
    end

endmodule

`default_nettype wire

@@ hdl/length_framed_packet_deframer_top.sv @@
// ---------------------------------------------------------------------------
// length_framed_packet_deframer_top
// Splits length-framed packets out of a byte stream and delivers payload
// bytes and empty-packet notices of enabled channels with their header fields.
//
//   channel   dir   width  contents
//   s_        in    24+1   data_byte, bytes_left; tuser first_of_buffer
//   m_        out   40+2   payload byte + header fields; tuser has_payload
//   cfg_      in    8      channel_enable_mask write
//
// One byte is accepted per cycle while s_tready is high; the parser settles
// each byte combinationally with a counter and a compare. Results pass a
// 4-entry queue and then an output register on their way to m_tvalid.
// s_tready drops only while the queue is full under m_tready backpressure.
// aresetn is synchronous; cfg_ready is always high.
// ---------------------------------------------------------------------------
`default_nettype none

module length_framed_packet_deframer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] data_byte, [23:8] bytes_left
    input  wire logic [0:0]  s_tuser,   // [0] first_of_buffer
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [7:0] payload_byte, [10:8] packet_channel,
                                        // [26:11] packet_length, [34:27] packet_sequence
    output logic [0:0]       m_tuser,   // [0] has_payload
    output logic             m_tlast,   // last_of_packet
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data   // channel_enable_mask
);

    logic           q_full, q_not_empty, push, pop, out_user;
    lpd_pkg::item_t push_item, head_item;

    assign cfg_ready  = 1'b1;
    assign m_tuser[0] = out_user;

    lpd_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .data_byte       (s_tdata[7:0]),
        .bytes_left      (s_tdata[23:8]),
        .first_of_buffer (s_tuser[0]),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_mask        (cfg_data),
        .q_full          (q_full),
        .push            (push),
        .push_item       (push_item)
    );

    lpd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    lpd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_item      (head_item),
        .q_pop       (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (m_tdata),
        .out_user    (out_user),
        .out_last    (m_tlast)
    );

endmodule

`default_nettype wire

@@ hdl/lpd_checker.sv @@
// ---------------------------------------------------------------------------
// lpd_checker
// Port-level checks on the deframer result stream, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "length_framed_packet_deframer_top_assert.svh"

module lpd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [0:0]  m_tuser,
    input wire logic        m_tlast
);

    // hold a stalled result
    `LPD_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
    // a notice closes its packet and carries a zero byte
    `LPD_ASSERT(a_notice_form, aclk, aresetn, m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata[7:0] == 8'd0))
    // a payload byte comes from a packet with nonzero length
    `LPD_ASSERT(a_payload_len, aclk, aresetn, m_tvalid && m_tuser[0] |-> (m_tdata[26:11] != 16'd0))
    // reset empties the output stage
    `LPD_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid)

endmodule

bind length_framed_packet_deframer_top lpd_checker u_lpd_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
);

`default_nettype wire

@@ tb/length_framed_packet_deframer_monitor.sv @@
// ---------------------------------------------------------------------------
// length_framed_packet_deframer_monitor
// Watches the input, result and enable-mask channels of the deframer. Tracks
// the header parser on every accepted byte, queues the result each byte
// should give and compares every result transfer field by field.
// ---------------------------------------------------------------------------
module length_framed_packet_deframer_monitor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output int          fail_count,
    output int          results_due,
    output int          results_seen,
    output int          notices_seen
);

    typedef enum logic [2:0] {
        HDR_START,
        HDR_CHAN_HI,
        HDR_CHAN_LO,
        HDR_LEN_HI,
        HDR_LEN_LO,
        HDR_SEQ
    } hdr_pos_t;

    hdr_pos_t    hdr_pos;
    logic [7:0]  enable_mask;
    logic [15:0] hold_chan;
    logic [15:0] hold_len;
    logic [7:0]  hold_seq;
    logic [15:0] pay_left;
    logic        dropping;

    lpd_pkg::item_t due_items[$];

    function automatic logic chan_enabled(input logic [15:0] ch);
        return (ch < 16'(lpd_pkg::MASK_BITS)) && enable_mask[ch[lpd_pkg::CH_W-1:0]];
    endfunction

    function automatic lpd_pkg::item_t packet_item(input logic [7:0] d, input logic has,
                                                   input logic last);
        lpd_pkg::item_t it;
        it.data_byte    = d;
        it.channel      = hold_chan[lpd_pkg::CH_W-1:0];
        it.length       = hold_len;
        it.sequence_num = hold_seq;
        it.has_payload  = has;
        it.last         = last;
        return it;
    endfunction

    // advance the parser by one accepted byte
    task automatic parse_rx_byte(input logic [7:0] rx_byte, input logic [15:0] left,
                                 input logic first, output logic made_one,
                                 output lpd_pkg::item_t made);
        logic [15:0] after;
        after    = (left != 16'd0) ? left - 16'd1 : 16'd0;
        made_one = 1'b0;
        made     = '0;
        if (first) begin
            dropping = 1'b0;
            hdr_pos  = HDR_START;
            pay_left = 16'd0;
        end
        if (dropping) begin
            if (left <= 16'd1) dropping = 1'b0;
        end else if (pay_left != 16'd0) begin
            pay_left = pay_left - 16'd1;
            if (chan_enabled(hold_chan)) begin
                made_one = 1'b1;
                made     = packet_item(rx_byte, 1'b1, pay_left == 16'd0);
            end
        end else begin
            case (hdr_pos)
                HDR_START: begin
                    // a header cannot fit in what is left: drop the tail
                    if (left < 16'(lpd_pkg::HEADER_BYTES)) dropping = (left > 16'd1);
                    else hdr_pos = HDR_CHAN_HI;
                end
                HDR_CHAN_HI: begin
                    hold_chan = {rx_byte, 8'h00};
                    hdr_pos   = HDR_CHAN_LO;
                end
                HDR_CHAN_LO: begin
                    hold_chan[7:0] = rx_byte;
                    hdr_pos        = HDR_LEN_HI;
                end
                HDR_LEN_HI: begin
                    hold_len = {rx_byte, 8'h00};
                    hdr_pos  = HDR_LEN_LO;
                end
                HDR_LEN_LO: begin
                    hold_len[7:0] = rx_byte;
                    hdr_pos       = HDR_SEQ;
                end
                default: begin
                    hold_seq = rx_byte;
                    hdr_pos  = HDR_START;
                    if (hold_chan >= 16'(lpd_pkg::CHANNEL_TOTAL) || hold_len > after) begin
                        dropping = (left > 16'd1);
                    end else if (hold_len != 16'd0) begin
                        pay_left = hold_len;
                    end else if (chan_enabled(hold_chan)) begin
                        made_one = 1'b1;
                        made     = packet_item(8'h00, 1'b0, 1'b1);
                    end
                end
            endcase
        end
    endtask

    always @(posedge aclk) begin : watch
        lpd_pkg::item_t want;
        lpd_pkg::item_t got;
        lpd_pkg::item_t made;
        logic  made_one;
        if (!aresetn) begin
            hdr_pos      = HDR_START;
            enable_mask  = 8'h00;
            hold_chan    = 16'd0;
            hold_len     = 16'd0;
            hold_seq     = 8'd0;
            pay_left     = 16'd0;
            dropping     = 1'b0;
            due_items.delete();
            fail_count   = 0;
            results_seen = 0;
            notices_seen = 0;
        end else begin
            if (cfg_valid && cfg_ready) enable_mask = cfg_data;

            // results come out of registers behind their input: compare first
            if (m_tvalid && m_tready) begin
                got.data_byte    = m_tdata[7:0];
                got.channel      = m_tdata[10:8];
                got.length       = m_tdata[26:11];
                got.sequence_num = m_tdata[34:27];
                got.has_payload  = m_tuser[0];
                got.last         = m_tlast;
                results_seen++;
                if (!got.has_payload) notices_seen++;
                if (due_items.size() == 0) begin
                    $error("result transfer with nothing expected: m_tdata %h", m_tdata);
                    fail_count++;
                end else begin
                    want = due_items.pop_front();
                    if (got.data_byte !== want.data_byte) begin
                        $error("payload_byte mismatch: expected %0h, actual %0h",
                               want.data_byte, got.data_byte);
                        fail_count++;
                    end
                    if (got.channel !== want.channel) begin
                        $error("packet_channel mismatch: expected %0h, actual %0h",
                               want.channel, got.channel);
                        fail_count++;
                    end
                    if (got.length !== want.length) begin
                        $error("packet_length mismatch: expected %0h, actual %0h",
                               want.length, got.length);
                        fail_count++;
                    end
                    if (got.sequence_num !== want.sequence_num) begin
                        $error("packet_sequence mismatch: expected %0h, actual %0h",
                               want.sequence_num, got.sequence_num);
                        fail_count++;
                    end
                    if (got.has_payload !== want.has_payload) begin
                        $error("has_payload mismatch: expected %0h, actual %0h",
                               want.has_payload, got.has_payload);
                        fail_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("last_of_packet mismatch: expected %0h, actual %0h",
                               want.last, got.last);
                        fail_count++;
                    end
                    if (m_tdata[39:35] !== 5'd0) begin
                        $error("m_tdata padding mismatch: expected 0, actual %0h",
                               m_tdata[39:35]);
                        fail_count++;
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                parse_rx_byte(s_tdata[7:0], s_tdata[23:8], s_tuser[0], made_one, made);
                if (made_one) due_items.push_back(made);
            end
        end
        results_due = due_items.size();
    end

endmodule

@@ tb/length_framed_packet_deframer_top_test.sv @@
// ---------------------------------------------------------------------------
// length_framed_packet_deframer_top_test
// Feeds receive buffers of length-framed packets into the deframer: a short
// directed set, then random phases of clean, truncated, overclaimed and
// oversized frames mixed with noise, under several channel enable masks and
// random stalls on both sides. The monitor predicts and checks every result.
// ---------------------------------------------------------------------------
module length_framed_packet_deframer_top_test;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BYTES   = 105;
    localparam int PHASE_COUNT   = 7;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;

    int fail_count;
    int results_due;
    int results_seen;
    int notices_seen;

    int cycle_count   = 0;
    int bytes_sent    = 0;
    int mask_writes   = 0;
    int rx_stall_left = 0;
    bit tx_eager      = 1'b1;
    bit rx_eager      = 1'b1;
    bit hold_req      = 1'b0;

    logic [7:0] frame_bytes[$];

    length_framed_packet_deframer_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    length_framed_packet_deframer_monitor u_monitor (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .results_due  (results_due),
        .results_seen (results_seen),
        .notices_seen (notices_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("length_framed_packet_deframer_top_test failed");
            $finish;
        end
    end

    // result side: random ready, with short and long stalls and one long hold
    initial begin
        int roll;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            if (rx_stall_left > 0) begin
                rx_stall_left--;
                m_tready <= 1'b0;
            end else if (rx_eager) begin
                m_tready <= 1'b1;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 75) begin
                    m_tready <= 1'b1;
                end else if (roll < 95) begin
                    rx_stall_left = $urandom_range(0, 2);
                    m_tready <= 1'b0;
                end else begin
                    rx_stall_left = $urandom_range(9, 39);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    function automatic int tx_gap_pick();
        int roll;
        if (tx_eager) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // offer one byte, idling first if a gap is drawn; returns at a falling edge
    task automatic send_byte(input logic [7:0] rx_byte, input logic [15:0] left,
                             input logic first);
        int gap;
        gap = tx_gap_pick();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {left, rx_byte};
        s_tuser  <= first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic add_packet(input logic [15:0] ch, input logic [15:0] hdr_len,
                              input logic [7:0] seq_num, input int pay_n);
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        frame_bytes.push_back(ch[15:8]);
        frame_bytes.push_back(ch[7:0]);
        frame_bytes.push_back(hdr_len[15:8]);
        frame_bytes.push_back(hdr_len[7:0]);
        frame_bytes.push_back(seq_num);
        repeat (pay_n) frame_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // bytes_left counts down from the claimed size, which may exceed what is sent
    task automatic send_frame(input int claimed, input int send_n);
        for (int i = 0; i < send_n; i++) begin
            send_byte(frame_bytes[i], 16'(claimed - i), i == 0);
        end
        frame_bytes.delete();
    endtask

    task automatic build_random_frame(output int claimed, output int send_n);
        int          pk_n;
        int          pay_n;
        int          roll;
        int          shape;
        logic [15:0] ch;
        logic [15:0] hdr_len;
        frame_bytes.delete();
        pk_n  = $urandom_range(1, 4);
        shape = $urandom_range(0, 99);
        for (int k = 0; k < pk_n; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 88) ch = 16'($urandom_range(0, 7));
            else if (roll < 94) ch = 16'hFFFF;
            else ch = 16'($urandom_range(8, 65535));
            roll = $urandom_range(0, 99);
            if (roll < 20) pay_n = 0;
            else if (roll < 90) pay_n = $urandom_range(1, 12);
            else if (roll < 98) pay_n = $urandom_range(13, 60);
            else pay_n = $urandom_range(100, 300);
            hdr_len = 16'(pay_n);
            // overstate the last length; the fit check fails unless a junk tail covers it
            if (shape >= 90 && k == pk_n - 1) hdr_len = 16'(pay_n + $urandom_range(1, 3));
            add_packet(ch, hdr_len, 8'($urandom_range(0, 255)), pay_n);
        end
        // junk tail too short for a header
        if ($urandom_range(0, 99) < 25) begin
            repeat ($urandom_range(1, 5)) frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
        claimed = frame_bytes.size();
        send_n  = claimed;
        if (shape >= 70 && shape < 80) send_n = $urandom_range(1, claimed - 1);
        else if (shape >= 80 && shape < 90) claimed += $urandom_range(1, 65535 - claimed);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 8)) begin
            send_byte(8'($urandom_range(0, 255)), 16'($urandom_range(1, 65535)),
                      $urandom_range(0, 99) < 30);
        end
    endtask

    task automatic wait_idle();
        while (results_due != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_mask(input logic [7:0] mask);
        cfg_valid <= 1'b1;
        cfg_data  <= mask;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        mask_writes++;
    endtask

    initial begin
        int claimed;
        int send_n;
        int phase_start;
        logic [7:0] mask;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: channel 7 disabled
        write_mask(8'h7F);
        tx_eager = 1'b1;
        rx_eager = 1'b1;
        // empty notice, then a one-byte payload that fills the buffer exactly
        add_packet(16'h0000, 16'h0000, 8'hFF, 0);
        add_packet(16'h0003, 16'h0001, 8'h00, 0);
        frame_bytes.push_back(8'hFF);
        send_frame(13, 13);
        // disabled channel at the largest bytes_left, cut short by a new buffer
        add_packet(16'h0007, 16'h0002, 8'h55, 0);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h00);
        send_frame(65535, 7);
        // header start with too few bytes left, drop ends at bytes_left of 1
        send_byte(8'hA5, 16'd3, 1'b1);
        send_byte(8'h5A, 16'd1, 1'b0);
        // channel out of range with an oversized length: rest is dropped
        add_packet(16'h0100, 16'hFFFF, 8'h01, 0);
        frame_bytes.push_back(8'h3C);
        send_frame(7, 7);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            s_tvalid <= 1'b0;
            wait_idle();
            case (phase)
                0, 1:    mask = 8'hFF;
                2:       mask = 8'h00;
                3:       mask = 8'h01;
                4:       mask = 8'h80;
                default: mask = 8'($urandom_range(0, 255));
            endcase
            write_mask(mask);
            tx_eager = (phase <= 1) || ($urandom_range(0, 3) == 0);
            rx_eager = (phase == 0) || (phase > 1 && $urandom_range(0, 3) == 0);
            // hold the result side while bytes keep coming, so the input stalls
            if (phase == 1) hold_req = 1'b1;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                if ($urandom_range(0, 99) < 10) begin
                    send_noise();
                end else begin
                    build_random_frame(claimed, send_n);
                    send_frame(claimed, send_n);
                end
            end
        end

        s_tvalid <= 1'b0;
        wait_idle();
        $display("sent %0d input bytes across %0d enable-mask settings",
                 bytes_sent, mask_writes);
        $display("checked %0d result transfers, %0d of them empty-packet notices",
                 results_seen, notices_seen);
        if (fail_count == 0 && results_due == 0) begin
            $display("length_framed_packet_deframer_top_test passed");
        end else begin
            $display("length_framed_packet_deframer_top_test failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/lpd_pkg.sv
hdl/lpd_front.sv
hdl/lpd_queue.sv
hdl/lpd_back.sv
hdl/length_framed_packet_deframer_top.sv
hdl/lpd_checker.sv
tb/length_framed_packet_deframer_monitor.sv
tb/length_framed_packet_deframer_top_test.sv
